// File: rtl/vtypr_pkg.sv
// ============================================================================
// vtypr_pkg
// Shared types, constants and tables for the vector to yaw/pitch/range core.
// ============================================================================
package vtypr_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int THRESH_WIDTH = 16;

    // Sums of three squares stay below 2^(2*COORD_WIDTH).
    localparam int SQ_WIDTH = 2 * COORD_WIDTH;
    localparam int CMP_WIDTH = (COORD_WIDTH > THRESH_WIDTH) ? COORD_WIDTH : THRESH_WIDTH;

    localparam int CORDIC_STEPS = 32;
    localparam int CORDIC_WIDTH = 64;
    localparam int NORM_TOP = 60;
    localparam int NORM_LEVELS = 6;
    localparam int NORM_IDX_WIDTH = $clog2(NORM_LEVELS);
    localparam int SHIFT_WIDTH = $clog2(CORDIC_WIDTH);
    // The counter covers both the square root steps and the rotation steps.
    localparam int CNT_WIDTH = $clog2(CORDIC_STEPS);

    localparam int ANGLE_DROP = 32 - ANGLE_WIDTH;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
        logic signed [COORD_WIDTH-1:0] z_coord;
    } in_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic [COORD_WIDTH-1:0]        vector_length;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Z,
        ST_SQ_Y,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_CHECK,
        ST_NORM,
        ST_ROT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Z,
        SEL_Y
    } sq_sel_t;

    typedef struct packed {
        logic                 load_in;
        logic                 mul_en;
        sq_sel_t              mul_sel;
        logic                 sqrt_load;
        logic                 sqrt_step;
        logic                 cordic_load;
        logic                 norm_step;
        logic                 rot_step;
        logic [CNT_WIDTH-1:0] step_idx;
        logic                 finish;
    } cmd_t;

    typedef struct packed {
        logic range_zero;
        logic horiz_zero;
    } status_t;

    // Shift applied by each normalization level: 32, 16, 8, 4, 2, 1.
    function automatic logic [SHIFT_WIDTH-1:0] norm_shift(input logic [NORM_IDX_WIDTH-1:0] lvl);
        logic [SHIFT_WIDTH-1:0] sh;
        case (lvl)
            3'd0:    sh = 6'd32;
            3'd1:    sh = 6'd16;
            3'd2:    sh = 6'd8;
            3'd3:    sh = 6'd4;
            3'd4:    sh = 6'd2;
            3'd5:    sh = 6'd1;
            default: sh = 6'd0;
        endcase
        return sh;
    endfunction

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [31:0] atan_step(input logic [CNT_WIDTH-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/vtypr_sqrt.sv
// ============================================================================
// vtypr_sqrt
// Bit-serial integer square root, one result bit per step.
// ============================================================================
module vtypr_sqrt (
    input  logic                             clk,
    input  vtypr_pkg::cmd_t                  cmd,
    input  logic [vtypr_pkg::SQ_WIDTH-1:0]   operand,
    output logic [vtypr_pkg::COORD_WIDTH-1:0] root
);

    localparam int W = vtypr_pkg::SQ_WIDTH;

    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] res_reg, res_next;
    logic [W-1:0] bit_reg, bit_next;
    logic [W:0]   trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (cmd.sqrt_load)
        begin
            rem_next = operand;
            res_next = '0;
            bit_next = W'(1) << (W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root = res_reg[vtypr_pkg::COORD_WIDTH-1:0];

endmodule

// File: rtl/vtypr_cordic.sv
// ============================================================================
// vtypr_cordic
// Iterative CORDIC vectoring unit: half-turn fold, normalization and
// one rotation per step, giving atan2(a, b) as a 32-bit binary angle.
// ============================================================================
module vtypr_cordic (
    input  logic                                 clk,
    input  vtypr_pkg::cmd_t                      cmd,
    input  logic signed [vtypr_pkg::COORD_WIDTH:0] a_in,
    input  logic signed [vtypr_pkg::COORD_WIDTH:0] b_in,
    output logic [31:0]                          angle
);

    localparam int W = vtypr_pkg::CORDIC_WIDTH;
    localparam int IW = vtypr_pkg::COORD_WIDTH + 1;
    localparam int SHIFT_WIDTH = vtypr_pkg::SHIFT_WIDTH;

    logic signed [W-1:0] a_reg, a_next;
    logic signed [W-1:0] b_reg, b_next;
    logic [W-1:0]        big_reg, big_next;
    logic [31:0]         ang_reg, ang_next;

    logic signed [W-1:0] a_ext, b_ext;
    logic [W-1:0]        a_mag, b_mag;
    logic [vtypr_pkg::SHIFT_WIDTH-1:0] sh;
    logic signed [W-1:0] da, db;
    logic [31:0]         step_ang;

    assign a_ext = {{(W - IW){a_in[IW-1]}}, a_in};
    assign b_ext = {{(W - IW){b_in[IW-1]}}, b_in};
    assign a_mag = a_ext[W-1] ? W'(-a_ext) : W'(a_ext);
    assign b_mag = b_ext[W-1] ? W'(-b_ext) : W'(b_ext);

    assign sh = vtypr_pkg::norm_shift(cmd.step_idx[vtypr_pkg::NORM_IDX_WIDTH-1:0]);
    assign da = a_reg >>> cmd.step_idx;
    assign db = b_reg >>> cmd.step_idx;
    assign step_ang = vtypr_pkg::atan_step(cmd.step_idx);

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        big_next = big_reg;
        ang_next = ang_reg;
        if (cmd.cordic_load)
        begin
            // A vector with negative b is folded by a half turn.
            if (b_ext < 0)
            begin
                a_next = -a_ext;
                b_next = -b_ext;
                ang_next = vtypr_pkg::HALF_TURN;
            end
            else
            begin
                a_next = a_ext;
                b_next = b_ext;
                ang_next = '0;
            end
            big_next = (a_mag > b_mag) ? a_mag : b_mag;
        end
        else if (cmd.norm_step)
        begin
            // Shift only while the larger magnitude stays below 2^60.
            if ((big_reg >> (SHIFT_WIDTH'(vtypr_pkg::NORM_TOP) - sh)) == '0)
            begin
                a_next = a_reg <<< sh;
                b_next = b_reg <<< sh;
                big_next = big_reg << sh;
            end
        end
        else if (cmd.rot_step)
        begin
            if (a_reg > 0)
            begin
                b_next = b_reg + da;
                a_next = a_reg - db;
                ang_next = ang_reg + step_ang;
            end
            else
            begin
                b_next = b_reg - da;
                a_next = a_reg + db;
                ang_next = ang_reg - step_ang;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        big_reg <= big_next;
        ang_reg <= ang_next;
    end

    assign angle = ang_reg;

endmodule

// File: rtl/vtypr_datapath.sv
// ============================================================================
// vtypr_datapath
// Input capture, squaring, two square roots, two CORDIC units, threshold
// checks and the result register.
// ============================================================================
module vtypr_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vtypr_pkg::cmd_t                      cmd,
    input  vtypr_pkg::in_t                       in_data,
    input  logic                                 cfg_wr_en,
    input  logic [vtypr_pkg::THRESH_WIDTH-1:0]   cfg_wr_data,
    output vtypr_pkg::status_t                   status,
    output vtypr_pkg::out_t                      out_data
);

    localparam int CW = vtypr_pkg::COORD_WIDTH;
    localparam int AW = vtypr_pkg::ANGLE_WIDTH;
    localparam int SW = vtypr_pkg::SQ_WIDTH;
    localparam int MW = vtypr_pkg::CMP_WIDTH;

    logic [vtypr_pkg::THRESH_WIDTH-1:0] thr_reg;
    vtypr_pkg::in_t  in_reg;
    vtypr_pkg::out_t out_reg, out_next;
    logic [SW-1:0]   hsq_reg, sum_reg;

    logic [CW-1:0] mag_x, mag_y, mag_z, mul_op;
    logic [SW-1:0] prod;
    logic [CW-1:0] range_root, horiz_root;
    logic [31:0]   yaw_raw, pitch_raw;
    logic [AW-1:0] yaw_rnd, pitch_rnd;
    logic          y_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= vtypr_pkg::THRESH_WIDTH'(1);
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    assign mag_x = in_reg.x_coord[CW-1] ? (~in_reg.x_coord + 1'b1) : in_reg.x_coord;
    assign mag_y = in_reg.y_coord[CW-1] ? (~in_reg.y_coord + 1'b1) : in_reg.y_coord;
    assign mag_z = in_reg.z_coord[CW-1] ? (~in_reg.z_coord + 1'b1) : in_reg.z_coord;

    always_comb
    begin
        case (cmd.mul_sel)
            vtypr_pkg::SEL_X: mul_op = mag_x;
            vtypr_pkg::SEL_Z: mul_op = mag_z;
            vtypr_pkg::SEL_Y: mul_op = mag_y;
            default:          mul_op = mag_x;
        endcase
    end

    assign prod = SW'(mul_op) * SW'(mul_op);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                vtypr_pkg::SEL_X: hsq_reg <= prod;
                vtypr_pkg::SEL_Z: hsq_reg <= hsq_reg + prod;
                vtypr_pkg::SEL_Y: sum_reg <= hsq_reg + prod;
                default:          hsq_reg <= prod;
            endcase
        end
    end

    vtypr_sqrt u_sqrt_range (
        .clk     (clk),
        .cmd     (cmd),
        .operand (sum_reg),
        .root    (range_root)
    );

    vtypr_sqrt u_sqrt_horiz (
        .clk     (clk),
        .cmd     (cmd),
        .operand (hsq_reg),
        .root    (horiz_root)
    );

    assign status.range_zero = MW'(range_root) <= MW'(thr_reg);
    assign status.horiz_zero = MW'(horiz_root) <= MW'(thr_reg);

    vtypr_cordic u_cordic_yaw (
        .clk   (clk),
        .cmd   (cmd),
        .a_in  ({in_reg.x_coord[CW-1], in_reg.x_coord}),
        .b_in  ({in_reg.z_coord[CW-1], in_reg.z_coord}),
        .angle (yaw_raw)
    );

    vtypr_cordic u_cordic_pitch (
        .clk   (clk),
        .cmd   (cmd),
        .a_in  ({in_reg.y_coord[CW-1], in_reg.y_coord}),
        .b_in  ({1'b0, horiz_root}),
        .angle (pitch_raw)
    );

    // Round to the output angle step by adding half a step, with wrap.
    if (vtypr_pkg::ANGLE_DROP > 0)
    begin : g_round
        localparam logic [31:0] HALF_LSB = 32'(1) << (vtypr_pkg::ANGLE_DROP - 1);
        logic [31:0] yaw_sum, pitch_sum;
        assign yaw_sum = yaw_raw + HALF_LSB;
        assign pitch_sum = pitch_raw + HALF_LSB;
        assign yaw_rnd = yaw_sum[31 -: AW];
        assign pitch_rnd = pitch_sum[31 -: AW];
    end
    else
    begin : g_noround
        assign yaw_rnd = yaw_raw[AW-1:0];
        assign pitch_rnd = pitch_raw[AW-1:0];
    end

    assign y_pos = !in_reg.y_coord[CW-1] && (in_reg.y_coord != '0);

    always_comb
    begin
        out_next = out_reg;
        out_next.vector_length = range_root;
        if (status.range_zero)
        begin
            out_next.yaw_angle = '0;
            out_next.pitch_angle = '0;
        end
        else if (status.horiz_zero)
        begin
            // Straight up or down: pitch is a quarter turn of opposite sign to y.
            out_next.yaw_angle = '0;
            out_next.pitch_angle = y_pos ? (~vtypr_pkg::QUARTER_TURN + 1'b1)
                                         : vtypr_pkg::QUARTER_TURN;
        end
        else
        begin
            out_next.yaw_angle = yaw_rnd;
            out_next.pitch_angle = ~pitch_rnd + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// File: rtl/vtypr_ctrl.sv
// ============================================================================
// vtypr_ctrl
// Sequencer for one transaction: squaring, square roots, threshold check,
// CORDIC normalization and rotation, result strobe.
// ============================================================================
module vtypr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  vtypr_pkg::status_t status,
    output vtypr_pkg::cmd_t    cmd,
    output logic               busy,
    output logic               done
);

    localparam int NW = vtypr_pkg::CNT_WIDTH;

    vtypr_pkg::state_t state_reg, state_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic              done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vtypr_pkg::ST_IDLE;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        cmd.step_idx = cnt_reg;
        case (state_reg)
            vtypr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    state_next = vtypr_pkg::ST_SQ_X;
                end
            end
            vtypr_pkg::ST_SQ_X:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = vtypr_pkg::SEL_X;
                state_next = vtypr_pkg::ST_SQ_Z;
            end
            vtypr_pkg::ST_SQ_Z:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = vtypr_pkg::SEL_Z;
                state_next = vtypr_pkg::ST_SQ_Y;
            end
            vtypr_pkg::ST_SQ_Y:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = vtypr_pkg::SEL_Y;
                state_next = vtypr_pkg::ST_SQRT_LOAD;
            end
            vtypr_pkg::ST_SQRT_LOAD:
            begin
                cmd.sqrt_load = 1'b1;
                cnt_next = '0;
                state_next = vtypr_pkg::ST_SQRT;
            end
            vtypr_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == NW'(vtypr_pkg::COORD_WIDTH - 1))
                begin
                    cnt_next = '0;
                    state_next = vtypr_pkg::ST_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vtypr_pkg::ST_CHECK:
            begin
                // Degenerate vectors skip the angle search altogether.
                cmd.cordic_load = 1'b1;
                cnt_next = '0;
                if (status.range_zero || status.horiz_zero)
                begin
                    state_next = vtypr_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = vtypr_pkg::ST_NORM;
                end
            end
            vtypr_pkg::ST_NORM:
            begin
                cmd.norm_step = 1'b1;
                if (cnt_reg == NW'(vtypr_pkg::NORM_LEVELS - 1))
                begin
                    cnt_next = '0;
                    state_next = vtypr_pkg::ST_ROT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vtypr_pkg::ST_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (cnt_reg == NW'(vtypr_pkg::CORDIC_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = vtypr_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vtypr_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = vtypr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vtypr_pkg::ST_IDLE;
            end
        endcase
        done_next = cmd.finish;
    end

    assign busy = (state_reg != vtypr_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

// File: rtl/vector_to_yaw_pitch_range_core.sv
// ============================================================================
// vector_to_yaw_pitch_range_core
// Converts a signed 3D vector into yaw, pitch and range.
// ============================================================================
// Usage:
// A transaction is accepted on the rising edge where start is high and busy
// is low; in_data carries x_coord, y_coord and z_coord. busy stays high
// while the transaction is worked on. The result appears on out_data with
// done high for exactly one cycle; out_data then holds until the next result.
// The receiver cannot stall, so it must take the result in that cycle.
// An ordinary vector passes through squaring of x, z and y on one multiplier,
// a square root load and 16 square root steps for range and horizontal
// length in parallel, a check, 6 normalization and 32 rotation steps in two
// parallel CORDIC units, the write of the result register and the registered
// done strobe. A vector whose range or horizontal length falls at or below
// zero_threshold skips normalization and rotation. A new transaction can be
// accepted in the cycle done is high, but none while busy is high; the CORDIC
// rotation loop and the bit-serial square root set the length of a transaction.
// cfg_wr_en with cfg_wr_data writes zero_threshold; write it only while idle.
// Reset returns the controller to idle, clears done and sets the threshold
// to one.
// ============================================================================
module vector_to_yaw_pitch_range_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  vtypr_pkg::in_t                     in_data,
    input  logic                               cfg_wr_en,
    input  logic [vtypr_pkg::THRESH_WIDTH-1:0] cfg_wr_data,
    output logic                               done,
    output vtypr_pkg::out_t                    out_data
);

    vtypr_pkg::cmd_t    cmd;
    vtypr_pkg::status_t status;

    vtypr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    vtypr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .out_data    (out_data)
    );

endmodule

// File: rtl/vtypr_checker.sv
// ============================================================================
// vtypr_checker
// Port-level checks on the transaction sequencing of the core.
// ============================================================================
module vtypr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input vtypr_pkg::out_t                    out_data
);

    // The strobe only comes out once the sequencer is back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done asserted while busy");

    // An accepted transaction keeps the core busy and cannot finish at once.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not start");

    // busy never rises on its own.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // A zero length is at or below every threshold, so both angles must be zero.
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (out_data.vector_length == '0))
            |-> ((out_data.yaw_angle == '0) && (out_data.pitch_angle == '0)))
        else $error("nonzero angle for a zero-length vector");

endmodule

bind vector_to_yaw_pitch_range_core vtypr_checker u_checker (.*);
